/* rtl/core/clook_pkg.sv */
// clook_pkg: shared types, codes and default sizes for the c-look scheduler
// used by the interface file, the scan cell and the top level; no dependencies

package clook_pkg;

   // default sizes
   localparam int DEF_QUEUE_DEPTH   = 16;
   localparam int DEF_CYLINDER_BITS = 16;

   // fixed field widths of the channels
   localparam int CYL_FIELD_W   = 16;
   localparam int STATUS_W      = 2;
   localparam int TOTAL_W       = 32;
   localparam int PENDING_W     = 5;

   localparam logic [CYL_FIELD_W-1:0] MOVE_MAX = {CYL_FIELD_W{1'b1}};

   // operation codes
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_SERVE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ADDED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SERVED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

   // control part of the token that walks the cell chain
   typedef struct packed {
      logic active;
      logic op;
      logic placed;
      logic up_found;
      logic low_found;
   } token_ctl_type;

endpackage

/* rtl/core/clook_if.sv */
// clook_if: valid/ready channel interfaces of the c-look scheduler
// request, response and csr write channels; depends on clook_pkg

interface clook_req_if;
   logic                               valid;
   logic                               ready;
   logic                               operation;
   logic [clook_pkg::CYL_FIELD_W-1:0]  cylinder;

   modport source (output valid, output operation, output cylinder, input ready);
   modport sink   (input valid, input operation, input cylinder, output ready);
endinterface

interface clook_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [clook_pkg::STATUS_W-1:0]     status;
   logic [clook_pkg::CYL_FIELD_W-1:0]  served_cylinder;
   logic [clook_pkg::CYL_FIELD_W-1:0]  movement;
   logic [clook_pkg::TOTAL_W-1:0]      total_movement;
   logic [clook_pkg::PENDING_W-1:0]    pending_count;

   modport source (output valid, output status, output served_cylinder, output movement,
                   output total_movement, output pending_count, input ready);
   modport sink   (input valid, input status, input served_cylinder, input movement,
                   input total_movement, input pending_count, output ready);
endinterface

interface clook_csr_if;
   logic                               valid;
   logic                               ready;
   logic [clook_pkg::CYL_FIELD_W-1:0]  start_head;

   modport source (output valid, output start_head, input ready);
   modport sink   (input valid, input start_head, output ready);
endinterface

/* rtl/core/clook_disk_request_scheduler.sv */
// clook_disk_request_scheduler: c-look disk request scheduler, top level
// controller, head and travel registers, chain of clook_cell; needs clook_pkg, clook_if
//
// channel  dir  handshake      payload
// req_if   in   valid/ready    operation, cylinder
// rsp_if   out  valid/ready    status, served_cylinder, movement, total_movement,
//                              pending_count
// csr_if   in   valid/ready    start_head (always ready, also loads the head)
//
// each item runs through these steps from its request transfer: the transfer cycle, the
// token walking the cell chain one slot per cycle, capture of the pick at the chain end,
// the calc step that sets the status and, for a serve, the head, and adding the travel and
// loading the response register; a new request is taken only once the controller is back
// in idle after that last step.
// reset (synchronous) empties the table, puts the head at 0 and clears the total.
// a waiting response does not block the next request transfer; only a new result
// waits in the last step until the response register is free.

module clook_disk_request_scheduler #(
   parameter int QUEUE_DEPTH   = clook_pkg::DEF_QUEUE_DEPTH,
   parameter int CYLINDER_BITS = clook_pkg::DEF_CYLINDER_BITS
) (
   input  logic        clock,
   input  logic        reset,
   clook_req_if.sink   req_if,
   clook_rsp_if.source rsp_if,
   clook_csr_if.sink   csr_if
);

   localparam int CYL_W  = CYLINDER_BITS;
   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int FLD_W  = clook_pkg::CYL_FIELD_W;
   localparam int WIDE_W = (CYL_W > FLD_W) ? CYL_W : FLD_W;
   localparam int TOT_W  = clook_pkg::TOTAL_W;

   // controller states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_CALC = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0] state_ff, state_in;

   // head and running travel
   logic [CYL_W-1:0] head_ff, head_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // launch register feeding the first cell
   clook_pkg::token_ctl_type launch_ctl_ff, launch_ctl_in;
   logic [CYL_W-1:0]         launch_key_ff, launch_key_in;

   // chain end capture
   logic             op_ff, op_in;
   logic             hit_ff, hit_in;
   logic [CYL_W-1:0] pick_val_ff, pick_val_in;
   logic [IDX_W-1:0] pick_idx_ff, pick_idx_in;

   // result of the calc step
   logic [clook_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [CYL_W-1:0]               delta_ff, delta_in;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [clook_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FLD_W-1:0]               rsp_served_ff, rsp_served_in;
   logic [FLD_W-1:0]               rsp_move_ff, rsp_move_in;
   logic [TOT_W-1:0]               rsp_total_ff, rsp_total_in;
   logic [clook_pkg::PENDING_W-1:0] rsp_pend_ff, rsp_pend_in;

   // cell chain: index 0 is the launch register, index QUEUE_DEPTH the chain end
   clook_pkg::token_ctl_type chain_ctl     [QUEUE_DEPTH+1];
   logic [CYL_W-1:0]         chain_key     [QUEUE_DEPTH+1];
   logic [CYL_W-1:0]         chain_up_val  [QUEUE_DEPTH+1];
   logic [IDX_W-1:0]         chain_up_idx  [QUEUE_DEPTH+1];
   logic [CYL_W-1:0]         chain_low_val [QUEUE_DEPTH+1];
   logic [IDX_W-1:0]         chain_low_idx [QUEUE_DEPTH+1];

   logic             clear_en;
   logic             req_xfer, csr_xfer, rsp_free;
   logic [CYL_W-1:0] req_cyl, csr_head;
   logic [TOT_W:0]   sum_wide;
   logic [WIDE_W-1:0] move_wide;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_xfer     = req_if.valid && req_if.ready;
   assign csr_xfer     = csr_if.valid && csr_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   // cylinders are masked to CYLINDER_BITS
   assign req_cyl  = CYL_W'(WIDE_W'(req_if.cylinder));
   assign csr_head = CYL_W'(WIDE_W'(csr_if.start_head));

   assign chain_ctl[0]     = launch_ctl_ff;
   assign chain_key[0]     = launch_key_ff;
   assign chain_up_val[0]  = '0;
   assign chain_up_idx[0]  = '0;
   assign chain_low_val[0] = '0;
   assign chain_low_idx[0] = '0;

   // the table: one cell per slot, token moves one slot per cycle
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      clook_cell #(
         .CYL_W      (CYL_W),
         .IDX_W      (IDX_W),
         .CELL_INDEX (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl_in      (chain_ctl[k]),
         .key_in      (chain_key[k]),
         .up_val_in   (chain_up_val[k]),
         .up_idx_in   (chain_up_idx[k]),
         .low_val_in  (chain_low_val[k]),
         .low_idx_in  (chain_low_idx[k]),
         .clear_en    (clear_en),
         .clear_idx   (pick_idx_ff),
         .ctl_out     (chain_ctl[k+1]),
         .key_out     (chain_key[k+1]),
         .up_val_out  (chain_up_val[k+1]),
         .up_idx_out  (chain_up_idx[k+1]),
         .low_val_out (chain_low_val[k+1]),
         .low_idx_out (chain_low_idx[k+1])
      );
   end

   // served slot is freed in the calc step
   assign clear_en = (state_ff == S_CALC) && (op_ff == clook_pkg::OP_SERVE) && hit_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      count_in      = count_ff;
      launch_ctl_in = '0;
      launch_key_in = launch_key_ff;
      op_in         = op_ff;
      hit_in        = hit_ff;
      pick_val_in   = pick_val_ff;
      pick_idx_in   = pick_idx_ff;
      status_in     = status_ff;
      delta_in      = delta_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_served_in = rsp_served_ff;
      rsp_move_in   = rsp_move_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_pend_in   = rsp_pend_ff;

      // saturating travel sum
      sum_wide  = {1'b0, total_ff} + (TOT_W+1)'(delta_ff);
      move_wide = WIDE_W'(delta_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               // add carries the new cylinder, serve carries the head
               launch_ctl_in.active = 1'b1;
               launch_ctl_in.op     = req_if.operation;
               launch_key_in        = (req_if.operation == clook_pkg::OP_ADD) ? req_cyl
                                                                              : head_ff;
               op_in                = req_if.operation;
               state_in             = S_SCAN;
            end
         end
         S_SCAN: begin
            if (chain_ctl[QUEUE_DEPTH].active) begin
               if (op_ff == clook_pkg::OP_ADD) begin
                  hit_in = chain_ctl[QUEUE_DEPTH].placed;
               end else begin
                  hit_in = chain_ctl[QUEUE_DEPTH].low_found;
               end
               // nearest at or above the head, else wrap to the lowest
               if (chain_ctl[QUEUE_DEPTH].up_found) begin
                  pick_val_in = chain_up_val[QUEUE_DEPTH];
                  pick_idx_in = chain_up_idx[QUEUE_DEPTH];
               end else begin
                  pick_val_in = chain_low_val[QUEUE_DEPTH];
                  pick_idx_in = chain_low_idx[QUEUE_DEPTH];
               end
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            delta_in = '0;
            if (op_ff == clook_pkg::OP_ADD) begin
               if (hit_ff) begin
                  status_in = clook_pkg::ST_ADDED;
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  status_in = clook_pkg::ST_FULL;
               end
            end else if (hit_ff) begin
               status_in = clook_pkg::ST_SERVED;
               delta_in  = (pick_val_ff >= head_ff) ? (pick_val_ff - head_ff)
                                                    : (head_ff - pick_val_ff);
               head_in   = pick_val_ff;
               count_in  = count_ff - CNT_W'(1);
            end else begin
               status_in = clook_pkg::ST_EMPTY;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) begin
               total_in      = sum_wide[TOT_W] ? {TOT_W{1'b1}} : sum_wide[TOT_W-1:0];
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_served_in = (status_ff == clook_pkg::ST_SERVED)
                               ? FLD_W'(WIDE_W'(pick_val_ff)) : '0;
               rsp_move_in   = (move_wide > WIDE_W'(clook_pkg::MOVE_MAX))
                               ? clook_pkg::MOVE_MAX : FLD_W'(move_wide);
               rsp_total_in  = total_in;
               rsp_pend_in   = clook_pkg::PENDING_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // csr transfer loads the head directly
      if (csr_xfer) begin
         head_in = csr_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         total_ff      <= '0;
         count_ff      <= '0;
         launch_ctl_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         total_ff      <= total_in;
         count_ff      <= count_in;
         launch_ctl_ff <= launch_ctl_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      launch_key_ff <= launch_key_in;
      op_ff         <= op_in;
      hit_ff        <= hit_in;
      pick_val_ff   <= pick_val_in;
      pick_idx_ff   <= pick_idx_in;
      status_ff     <= status_in;
      delta_ff      <= delta_in;
      rsp_status_ff <= rsp_status_in;
      rsp_served_ff <= rsp_served_in;
      rsp_move_ff   <= rsp_move_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_pend_ff   <= rsp_pend_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_status_ff;
   assign rsp_if.served_cylinder = rsp_served_ff;
   assign rsp_if.movement        = rsp_move_ff;
   assign rsp_if.total_movement  = rsp_total_ff;
   assign rsp_if.pending_count   = rsp_pend_ff;

endmodule

/* rtl/core/clook_cell.sv */
// clook_cell: one table slot of the scheduler chain (valid bit and cylinder)
// updates the passing token and hands it on; depends on clook_pkg

module clook_cell #(
   parameter int CYL_W      = clook_pkg::DEF_CYLINDER_BITS,
   parameter int IDX_W      = 4,
   parameter int CELL_INDEX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  clook_pkg::token_ctl_type  ctl_in,
   input  logic [CYL_W-1:0]          key_in,
   input  logic [CYL_W-1:0]          up_val_in,
   input  logic [IDX_W-1:0]          up_idx_in,
   input  logic [CYL_W-1:0]          low_val_in,
   input  logic [IDX_W-1:0]          low_idx_in,
   input  logic                      clear_en,
   input  logic [IDX_W-1:0]          clear_idx,
   output clook_pkg::token_ctl_type  ctl_out,
   output logic [CYL_W-1:0]          key_out,
   output logic [CYL_W-1:0]          up_val_out,
   output logic [IDX_W-1:0]          up_idx_out,
   output logic [CYL_W-1:0]          low_val_out,
   output logic [IDX_W-1:0]          low_idx_out
);

   logic                      valid_ff, valid_in;
   logic [CYL_W-1:0]          cyl_ff, cyl_in;
   clook_pkg::token_ctl_type  ctl_ff, ctl_nx_in;
   logic [CYL_W-1:0]          key_ff;
   logic [CYL_W-1:0]          up_val_ff, up_val_nx_in;
   logic [IDX_W-1:0]          up_idx_ff, up_idx_nx_in;
   logic [CYL_W-1:0]          low_val_ff, low_val_nx_in;
   logic [IDX_W-1:0]          low_idx_ff, low_idx_nx_in;

   logic take_write, is_serve, take_up, take_low, my_clear;

   always_comb begin
      take_write = ctl_in.active && (ctl_in.op == clook_pkg::OP_ADD)
                   && !ctl_in.placed && !valid_ff;
      is_serve   = ctl_in.active && (ctl_in.op == clook_pkg::OP_SERVE) && valid_ff;
      // strict compare keeps the lowest slot on equal cylinders
      take_up    = is_serve && (cyl_ff >= key_in)
                   && (!ctl_in.up_found || (cyl_ff < up_val_in));
      take_low   = is_serve && (!ctl_in.low_found || (cyl_ff < low_val_in));
      my_clear   = clear_en && (clear_idx == IDX_W'(CELL_INDEX));

      valid_in = valid_ff;
      cyl_in   = cyl_ff;
      if (take_write) begin
         valid_in = 1'b1;
         cyl_in   = key_in;
      end else if (my_clear) begin
         valid_in = 1'b0;
      end

      ctl_nx_in = ctl_in;
      if (take_write) begin
         ctl_nx_in.placed = 1'b1;
      end
      if (take_up) begin
         ctl_nx_in.up_found = 1'b1;
      end
      if (take_low) begin
         ctl_nx_in.low_found = 1'b1;
      end

      up_val_nx_in  = take_up  ? cyl_ff : up_val_in;
      up_idx_nx_in  = take_up  ? IDX_W'(CELL_INDEX) : up_idx_in;
      low_val_nx_in = take_low ? cyl_ff : low_val_in;
      low_idx_nx_in = take_low ? IDX_W'(CELL_INDEX) : low_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ctl_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         ctl_ff   <= ctl_nx_in;
      end
      cyl_ff     <= cyl_in;
      key_ff     <= key_in;
      up_val_ff  <= up_val_nx_in;
      up_idx_ff  <= up_idx_nx_in;
      low_val_ff <= low_val_nx_in;
      low_idx_ff <= low_idx_nx_in;
   end

   assign ctl_out     = ctl_ff;
   assign key_out     = key_ff;
   assign up_val_out  = up_val_ff;
   assign up_idx_out  = up_idx_ff;
   assign low_val_out = low_val_ff;
   assign low_idx_out = low_idx_ff;

endmodule

/* dv/clook_sched_check.sv */
// clook_sched_check: watches the request, response and csr channels of the c-look
// scheduler, predicts every response and compares it; needs clook_pkg and clook_if
`timescale 1ns / 1ps

module clook_sched_check (
   input  logic  clock,
   input  logic  reset,
   clook_req_if  req_mon,
   clook_rsp_if  rsp_mon,
   clook_csr_if  csr_mon,
   output int    fail_count,
   output int    results_due
);
   import clook_pkg::*;

   localparam int DEPTH = DEF_QUEUE_DEPTH;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [CYL_FIELD_W-1:0] served;
      logic [CYL_FIELD_W-1:0] move;
      logic [TOTAL_W-1:0]     total;
      logic [PENDING_W-1:0]   pending;
   } sched_result_type;

   logic [CYL_FIELD_W-1:0] slot_cyl  [DEPTH];
   logic                   slot_busy [DEPTH];
   logic [CYL_FIELD_W-1:0] head_pos;
   logic [TOTAL_W-1:0]     travel_total;
   sched_result_type       due_q [$];
   int                     errors = 0;

   // apply one request to the table copy and return the response it must give
   function automatic sched_result_type schedule_step(input logic op,
                                                      input logic [CYL_FIELD_W-1:0] cyl);
      sched_result_type       r;
      int                     free_slot;
      int                     up_slot;
      int                     low_slot;
      int                     pick;
      int                     busy_cnt;
      logic [CYL_FIELD_W-1:0] travel;
      r         = '0;
      free_slot = -1;
      up_slot   = -1;
      low_slot  = -1;
      busy_cnt  = 0;
      if (op == OP_ADD) begin
         for (int k = 0; k < DEPTH; k++)
            if (!slot_busy[k] && free_slot < 0) free_slot = k;
         if (free_slot < 0) begin
            r.status = ST_FULL;
         end else begin
            slot_cyl[free_slot]  = cyl;
            slot_busy[free_slot] = 1'b1;
            r.status             = ST_ADDED;
         end
      end else begin
         for (int k = 0; k < DEPTH; k++) begin
            if (slot_busy[k]) begin
               if (slot_cyl[k] >= head_pos &&
                   (up_slot < 0 || slot_cyl[k] < slot_cyl[up_slot])) up_slot = k;
               if (low_slot < 0 || slot_cyl[k] < slot_cyl[low_slot]) low_slot = k;
            end
         end
         if (low_slot < 0) begin
            r.status = ST_EMPTY;
         end else begin
            // c-look: nearest at or above the head, else wrap to the lowest
            pick = (up_slot >= 0) ? up_slot : low_slot;
            travel = (slot_cyl[pick] >= head_pos) ? slot_cyl[pick] - head_pos
                                                  : head_pos - slot_cyl[pick];
            slot_busy[pick] = 1'b0;
            head_pos        = slot_cyl[pick];
            if (travel_total > {TOTAL_W{1'b1}} - TOTAL_W'(travel))
               travel_total = {TOTAL_W{1'b1}};
            else
               travel_total = travel_total + TOTAL_W'(travel);
            r.status = ST_SERVED;
            r.served = slot_cyl[pick];
            r.move   = travel;
         end
      end
      for (int k = 0; k < DEPTH; k++)
         if (slot_busy[k]) busy_cnt++;
      r.total   = travel_total;
      r.pending = PENDING_W'(busy_cnt);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      sched_result_type got;
      sched_result_type want;
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            slot_busy[k] = 1'b0;
            slot_cyl[k]  = '0;
         end
         head_pos     = '0;
         travel_total = '0;
         due_q.delete();
      end else begin
         // responses first: one taken this edge belongs to an older request
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.status, rsp_mon.served_cylinder, rsp_mon.movement,
                    rsp_mon.total_movement, rsp_mon.pending_count};
            if (due_q.size() == 0) begin
               if (errors < 10)
                  $display("unexpected response: status=%0d served=%h move=%h total=%h pend=%0d",
                           got.status, got.served, got.move, got.total, got.pending);
               errors++;
            end else begin
               want = due_q.pop_front();
               if (got.status !== want.status || got.served !== want.served ||
                   got.move !== want.move || got.total !== want.total ||
                   got.pending !== want.pending) begin
                  if (errors < 10) begin
                     $display("mismatch exp: status=%0d served=%h move=%h total=%h pend=%0d",
                              want.status, want.served, want.move, want.total, want.pending);
                     $display("         got: status=%0d served=%h move=%h total=%h pend=%0d",
                              got.status, got.served, got.move, got.total, got.pending);
                  end
                  errors++;
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            head_pos = csr_mon.start_head;
         end
         if (req_mon.valid && req_mon.ready)
            due_q.push_back(schedule_step(req_mon.operation, req_mon.cylinder));
      end
      results_due <= due_q.size();
      fail_count  <= errors;
   end

endmodule

/* dv/clook_disk_request_scheduler_tb.sv */
// clook_disk_request_scheduler_tb: stimulus and verdict for the c-look scheduler
// drives req/csr channels and rsp backpressure; needs clook_pkg, clook_if, clook_sched_check
`timescale 1ns / 1ps

module clook_disk_request_scheduler_tb;
   import clook_pkg::*;

   // one item: transfer cycle, the whole cell chain, capture, head update and load steps
   localparam int ITEM_CYCLES = DEF_QUEUE_DEPTH + 4;

   // directed fill: both extremes, duplicates, single-bit and alternating patterns
   localparam logic [CYL_FIELD_W-1:0] FILL_CYLS [DEF_QUEUE_DEPTH] = '{
      16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA,
      16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h0002, 16'h7FFF, 16'h8001, 16'h0000
   };

   logic clock;
   logic reset;
   int   send_idle;     // percent of cycles the request side holds off
   int   recv_idle;     // percent of cycles the response side stalls
   int   fail_count;
   int   results_due;

   clook_req_if req_ch ();
   clook_rsp_if rsp_ch ();
   clook_csr_if csr_ch ();

   clook_disk_request_scheduler dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   clook_sched_check u_sched_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_mon     (csr_ch),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response backpressure, re-rolled every cycle at the current stall rate
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !reset && ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // one request transfer, with an optional idle gap in front of it;
   // valid stays high across back-to-back transfers
   task automatic send_req(input logic op, input logic [CYL_FIELD_W-1:0] cyl);
      if ($urandom_range(0, 99) < send_idle) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.cylinder  <= cyl;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold off requests until every response is back, then let the chain go quiet
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (ITEM_CYCLES) @(posedge clock);
   endtask

   // csr transfer; only issued while the block is idle
   task automatic write_start_head(input logic [CYL_FIELD_W-1:0] head);
      csr_ch.valid      <= 1'b1;
      csr_ch.start_head <= head;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // cylinders weighted toward the ends of the range and toward small clusters,
   // so duplicates, zero travel and wrap-around all come up often
   function automatic logic [CYL_FIELD_W-1:0] pick_cylinder();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return CYL_FIELD_W'($urandom_range(0, 15));
         3:       return 16'hFFF0 | CYL_FIELD_W'($urandom_range(0, 15));
         default: return CYL_FIELD_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int                     add_pct;
      logic [CYL_FIELD_W-1:0] seg_head;
      logic                   op;

      // every block input known from time zero
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.operation  <= OP_ADD;
      req_ch.cylinder   <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.start_head <= '0;
      send_idle = 26;
      recv_idle = 63;
      add_pct   = 50;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part, head still at its reset value
      // serve with nothing pending
      send_req(OP_SERVE, 16'h0000);
      // fill the table, duplicates included
      for (int k = 0; k < DEF_QUEUE_DEPTH; k++)
         send_req(OP_ADD, FILL_CYLS[k]);
      // add to a full table is rejected
      send_req(OP_ADD, 16'h1234);
      // serves ignore the cylinder field; equal cylinders come out one by one
      send_req(OP_SERVE, 16'hFFFF);
      send_req(OP_SERVE, 16'hA5A5);
      send_req(OP_SERVE, 16'h0000);
      send_req(OP_SERVE, 16'h5A5A);
      settle();

      // random part: six segments, two per idle pattern, each at its own start head
      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin send_idle = 26; recv_idle = 63; end
            1: begin send_idle = 63; recv_idle = 26; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         case (seg)
            0: seg_head = 16'hFFFF;
            1: seg_head = 16'h0000;
            3: seg_head = 16'h8000;
            5: seg_head = 16'h0001;
            default: seg_head = CYL_FIELD_W'($urandom);
         endcase
         write_start_head(seg_head);
         for (int n = 0; n < 115; n++) begin
            // shift the add/serve mix now and then so the table swings
            // between empty and full
            if (n % 20 == 0) add_pct = $urandom_range(15, 90);
            // occasional full drain with the request side held off
            if ($urandom_range(0, 49) == 0) settle();
            op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_SERVE;
            send_req(op, pick_cylinder());
         end
         settle();
      end

      if (fail_count == 0 && results_due == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/clook_pkg.sv
rtl/core/clook_if.sv
rtl/core/clook_cell.sv
rtl/core/clook_disk_request_scheduler.sv
dv/clook_sched_check.sv
dv/clook_disk_request_scheduler_tb.sv
